FILE: sv/sapd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sapd_pkg
// Shared constants, request codes and types of the serial phase dimmer.
// ----------------------------------------------------------------------------
package sapd_pkg;

   localparam int PHASE_STEPS   = 30;
   localparam int CHANNEL_COUNT = 8;
   localparam int MAX_CHANNELS  = 8;
   localparam int CHAN_IDX_W    = 3;
   localparam int LEVEL_W       = 5;
   localparam int POS_W         = 5;
   localparam int COUNTER_W     = 16;
   localparam int BYTE_W        = 8;
   localparam int REQ_W         = 2;

   localparam logic [REQ_W-1:0] REQ_BYTE       = 2'd0;
   localparam logic [REQ_W-1:0] REQ_ZERO_CROSS = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK       = 2'd2;
   localparam logic [REQ_W-1:0] REQ_UNUSED     = 2'd3;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'd117;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'd65;
   localparam logic [BYTE_W-1:0] ALL_OFF     = 8'hFF;
   localparam logic [BYTE_W-1:0] RESET_ADDR  = 8'd8;

   // x / 17 as (x * 482) >> 13, exact for x up to 518
   localparam int RECIP       = 482;
   localparam int RECIP_SHIFT = 13;

   typedef struct packed {
      logic [REQ_W-1:0]   kind;
      logic [BYTE_W-1:0]  rx_byte;
      logic [LEVEL_W-1:0] level;
   } op_type;

   // round(b / 8.5) as (2*b + 8) / 17
   function automatic logic [LEVEL_W-1:0] level_of(input logic [BYTE_W-1:0] b);
      logic [9:0]  x;
      logic [18:0] p;
      x = {1'b0, b, 1'b0} + 10'd8;
      p = 19'(x) * 19'(RECIP);
      return p[RECIP_SHIFT +: LEVEL_W];
   endfunction

endpackage
`default_nettype wire

FILE: sv/sapd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sapd_if
// Valid/ready channel interfaces for requests, responses and the CSR write.
// ----------------------------------------------------------------------------
interface sapd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] rx_byte;
   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface sapd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] channel_drive;
   logic       echo_valid;
   logic [7:0] echo_byte;
   modport source (output valid, output channel_drive, output echo_valid,
                   output echo_byte, input ready);
   modport sink   (input valid, input channel_drive, input echo_valid,
                   input echo_byte, output ready);
endinterface

interface sapd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/sapd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sapd_front
// Accepts requests, decodes the kind and precomputes the channel level.
// ----------------------------------------------------------------------------
module sapd_front
   import sapd_pkg::*;
(
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [REQ_W-1:0]   req_type,
   input  wire logic [BYTE_W-1:0]  rx_byte,
   input  wire logic               q_full,
   output      logic               q_push,
   output      op_type             q_op
);

   always_comb begin
      req_ready = !q_full;
      q_push    = req_valid && !q_full;
      q_op.kind    = req_type;
      q_op.rx_byte = rx_byte;
      q_op.level   = level_of(rx_byte);
   end

endmodule
`default_nettype wire

FILE: sv/sapd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sapd_queue
// Two-entry queue of decoded requests between front and back.
// ----------------------------------------------------------------------------
module sapd_queue
   import sapd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   output      logic   full,
   input  wire logic   pop,
   output      logic   empty,
   output      op_type pop_op
);

   op_type     entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      pop_op    = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

FILE: sv/sapd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sapd_back
// Executes decoded requests: chain addressing, levels, phase drive, response.
// ----------------------------------------------------------------------------
module sapd_back
   import sapd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic [BYTE_W-1:0] csr_data,
   input  wire logic              q_empty,
   input  wire op_type            q_op,
   output      logic              q_pop,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [BYTE_W-1:0] channel_drive,
   output      logic              echo_valid,
   output      logic [BYTE_W-1:0] echo_byte
);

   logic [BYTE_W-1:0]    addr_ff;
   logic [LEVEL_W-1:0]   level_ff [MAX_CHANNELS];
   logic [LEVEL_W-1:0]   level_in [MAX_CHANNELS];
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [COUNTER_W-1:0] counter_ff, counter_in;
   logic [BYTE_W-1:0]    prev_ff, prev_in;
   logic [BYTE_W-1:0]    drive_ff, drive_in;
   logic                 out_valid_ff;
   logic                 echo_valid_ff, echo_valid_in;
   logic [BYTE_W-1:0]    echo_byte_ff, echo_byte_in;

   logic [COUNTER_W-1:0] chan;
   logic [BYTE_W-1:0]    tick_drive;

   always_comb begin
      q_pop = !q_empty && (!out_valid_ff || rsp_ready);
      chan  = counter_ff - {{(COUNTER_W-BYTE_W){1'b0}}, addr_ff};

      tick_drive = ALL_OFF;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (c < CHANNEL_COUNT &&
             ({1'b0, pos_ff} + {1'b0, level_ff[c]}) >= (POS_W+1)'(PHASE_STEPS)) begin
            tick_drive[c] = 1'b0;
         end
      end

      level_in      = level_ff;
      pos_in        = pos_ff;
      counter_in    = counter_ff;
      prev_in       = prev_ff;
      drive_in      = drive_ff;
      echo_valid_in = 1'b0;
      echo_byte_in  = '0;

      case (q_op.kind)
         REQ_BYTE: begin
            if (q_op.rx_byte == SYNC_SECOND && prev_ff == SYNC_FIRST) begin
               counter_in = '0;
            end else begin
               if (chan < COUNTER_W'(CHANNEL_COUNT)) begin
                  level_in[chan[CHAN_IDX_W-1:0]] = q_op.level;
               end
               counter_in = counter_ff + 1'b1;
            end
            prev_in       = q_op.rx_byte;
            echo_valid_in = 1'b1;
            echo_byte_in  = q_op.rx_byte;
         end
         REQ_ZERO_CROSS: begin
            drive_in = ALL_OFF;
            pos_in   = '0;
         end
         REQ_TICK: begin
            if (pos_ff < POS_W'(PHASE_STEPS)) begin
               drive_in = tick_drive;
               pos_in   = pos_ff + 1'b1;
            end else begin
               drive_in = ALL_OFF;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= RESET_ADDR;
         pos_ff        <= '0;
         counter_ff    <= '0;
         prev_ff       <= '0;
         drive_ff      <= ALL_OFF;
         out_valid_ff  <= 1'b0;
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            level_ff[c] <= '0;
         end
      end else begin
         if (csr_write) begin
            addr_ff <= csr_data;
         end
         if (q_pop) begin
            pos_ff     <= pos_in;
            counter_ff <= counter_in;
            prev_ff    <= prev_in;
            drive_ff   <= drive_in;
            level_ff   <= level_in;
         end
         if (q_pop) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         echo_valid_ff <= echo_valid_in;
         echo_byte_ff  <= echo_byte_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign channel_drive = drive_ff;
   assign echo_valid    = echo_valid_ff;
   assign echo_byte     = echo_byte_ff;

endmodule
`default_nettype wire

FILE: sv/serial_addressed_phase_dimmer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_addressed_phase_dimmer
// Eight-channel phase-angle dimmer driven by a daisy-chained serial stream.
//
//   port      dir   carries
//   req_chan  in    request: req_type, rx_byte
//   rsp_chan  out   response: channel_drive, echo_valid, echo_byte
//   csr_chan  in    device_address write
//
// One request per cycle sustained while the response is not stalled; each
// request passes a queue entry, then the back-end output register.
// Throughput is set by the single back-end execute stage.
// Reset clears levels, phase, chain counter and queue; address returns to 8.
// A stalled response holds the back end; the queue keeps taking requests
// until both entries fill.
// ----------------------------------------------------------------------------
module serial_addressed_phase_dimmer
   import sapd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   sapd_req_if.sink   req_chan,
   sapd_rsp_if.source rsp_chan,
   sapd_csr_if.sink   csr_chan
);

   logic   q_push, q_pop, q_full, q_empty;
   op_type push_op, pop_op;

   assign csr_chan.ready = 1'b1;

   sapd_front u_front (
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_type  (req_chan.req_type),
      .rx_byte   (req_chan.rx_byte),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_op      (push_op)
   );

   sapd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (push_op),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .pop_op  (pop_op)
   );

   sapd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_chan.valid && csr_chan.ready),
      .csr_data      (csr_chan.data),
      .q_empty       (q_empty),
      .q_op          (pop_op),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .channel_drive (rsp_chan.channel_drive),
      .echo_valid    (rsp_chan.echo_valid),
      .echo_byte     (rsp_chan.echo_byte)
   );

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue full and empty at once");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !q_empty)
      else $error("queue empty after accepted request");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

   a_echo_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.echo_valid |-> rsp_chan.echo_byte == '0)
      else $error("echo byte set without echo valid");

endmodule
`default_nettype wire

FILE: bench/tb_serial_addressed_phase_dimmer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_addressed_phase_dimmer
// Self-checking bench for the serial phase dimmer. A scoreboard class keeps
// its own copy of the chain counter, channel levels and phase position. It
// predicts every response and compares it field by field in order.
// The stimulus is a directed opener, then framed chain traffic (zero-cross,
// sync pair, channel bytes, phase ticks) with noise mixed in. This runs under
// several device addresses and several idle/stall mixes, and includes one
// long receiver hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_serial_addressed_phase_dimmer;
   import sapd_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 150;

   typedef struct {
      logic [BYTE_W-1:0] drive;
      logic              echo_valid;
      logic [BYTE_W-1:0] echo_byte;
   } dimmer_out_type;

   class dimmer_scoreboard;
      logic [BYTE_W-1:0]    address;
      logic [LEVEL_W-1:0]   level [CHANNEL_COUNT];
      logic [POS_W-1:0]     position;
      logic [COUNTER_W-1:0] chain_count;
      logic [BYTE_W-1:0]    last_byte;
      logic [BYTE_W-1:0]    drive;
      dimmer_out_type       expected_out [$];
      int                   mismatches;

      function new();
         address     = RESET_ADDR;
         position    = '0;
         chain_count = '0;
         last_byte   = '0;
         drive       = ALL_OFF;
         mismatches  = 0;
         foreach (level[c]) level[c] = '0;
      endfunction

      function void set_address(logic [BYTE_W-1:0] addr);
         address = addr;
      endfunction

      function int pending();
         return expected_out.size();
      endfunction

      function void note_request(logic [REQ_W-1:0] kind, logic [BYTE_W-1:0] data);
         dimmer_out_type       e;
         logic [COUNTER_W-1:0] slot;
         logic [BYTE_W-1:0]    d;
         e.echo_valid = 1'b0;
         e.echo_byte  = '0;
         case (kind)
            REQ_BYTE: begin
               if (data == SYNC_SECOND && last_byte == SYNC_FIRST) begin
                  chain_count = '0;
               end else begin
                  slot = chain_count - COUNTER_W'(address);
                  if (slot < CHANNEL_COUNT)
                     level[slot[CHAN_IDX_W-1:0]] = LEVEL_W'((2 * int'(data) + 8) / 17);
                  chain_count = chain_count + 1'b1;
               end
               last_byte    = data;
               e.echo_valid = 1'b1;
               e.echo_byte  = data;
            end
            REQ_ZERO_CROSS: begin
               drive    = ALL_OFF;
               position = '0;
            end
            REQ_TICK: begin
               if (position < PHASE_STEPS) begin
                  d = ALL_OFF;
                  for (int c = 0; c < CHANNEL_COUNT; c++)
                     if (int'(position) + int'(level[c]) >= PHASE_STEPS) d[c] = 1'b0;
                  drive    = d;
                  position = position + 1'b1;
               end else begin
                  drive = ALL_OFF;
               end
            end
            default: ;
         endcase
         e.drive = drive;
         expected_out.push_back(e);
      endfunction

      function void check_response(logic [BYTE_W-1:0] drv, logic ev, logic [BYTE_W-1:0] eb);
         dimmer_out_type want;
         if (expected_out.size() == 0) begin
            $display("%0t: response with none expected: drive %h echo %b %h",
                     $time, drv, ev, eb);
            mismatches++;
            return;
         end
         want = expected_out.pop_front();
         if (drv !== want.drive) begin
            $display("%0t: channel_drive expected %h actual %h", $time, want.drive, drv);
            mismatches++;
         end
         if (ev !== want.echo_valid) begin
            $display("%0t: echo_valid expected %b actual %b", $time, want.echo_valid, ev);
            mismatches++;
         end
         if (eb !== want.echo_byte) begin
            $display("%0t: echo_byte expected %h actual %h", $time, want.echo_byte, eb);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic rsp_hold;
   int   send_idle_pct;
   int   stall_pct;
   int   requests_sent;
   int   idle_cycles;

   dimmer_scoreboard sb = new();

   sapd_req_if req_if ();
   sapd_rsp_if rsp_if ();
   sapd_csr_if csr_if ();

   serial_addressed_phase_dimmer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_if.ready <= !rsp_hold && ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.channel_drive, rsp_if.echo_valid, rsp_if.echo_byte);
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.req_type, req_if.rx_byte);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // starts and ends at a falling edge
   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [BYTE_W-1:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= kind;
      req_if.rx_byte  <= data;
      do @(posedge clock); while (!req_if.ready);
      requests_sent++;
      @(negedge clock);
   endtask

   // occasionally replaces the intended request with an arbitrary one
   task automatic send_noisy(input logic [REQ_W-1:0] kind, input logic [BYTE_W-1:0] data);
      if ($urandom_range(0, 9) == 0)
         send_request(REQ_W'($urandom_range(0, 3)), BYTE_W'($urandom));
      else
         send_request(kind, data);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_address(input logic [BYTE_W-1:0] addr);
      csr_if.valid <= 1'b1;
      csr_if.data  <= addr;
      do @(posedge clock); while (!csr_if.ready);
      sb.set_address(addr);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // zero-cross, sync pair, lead-in bytes up to the window, channel bytes, ticks
   task automatic send_frame(input int lead);
      int                n_ticks;
      logic [BYTE_W-1:0] b;
      send_request(REQ_ZERO_CROSS, BYTE_W'($urandom));
      send_request(REQ_BYTE, SYNC_FIRST);
      send_request(REQ_BYTE, SYNC_SECOND);
      for (int i = 0; i < lead + CHANNEL_COUNT; i++) begin
         case ($urandom_range(0, 5))
            0:       b = 8'd0;
            1:       b = BYTE_W'($urandom_range(245, 255));
            default: b = BYTE_W'($urandom);
         endcase
         send_noisy(REQ_BYTE, b);
      end
      n_ticks = ($urandom_range(0, 2) == 0) ? $urandom_range(31, 34) : $urandom_range(1, 30);
      for (int i = 0; i < n_ticks; i++) send_noisy(REQ_TICK, BYTE_W'($urandom));
   endtask

   task automatic run_phase(input logic [BYTE_W-1:0] addr, input int idle, input int stall,
                            input int quota, input bit hold);
      int first;
      write_address(addr);
      send_idle_pct = idle;
      stall_pct     = stall;
      first         = requests_sent;
      if (hold) begin
         fork
            begin
               @(posedge clock);
               rsp_hold <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               rsp_hold <= 1'b0;
            end
         join_none
      end
      while (requests_sent - first < quota) send_frame(addr);
      drain();
   endtask

   initial begin
      reset           = 1'b1;
      rsp_hold        = 1'b0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      requests_sent   = 0;
      idle_cycles     = 0;
      req_if.valid    = 1'b0;
      req_if.req_type = REQ_BYTE;
      req_if.rx_byte  = '0;
      rsp_if.ready    = 1'b0;
      csr_if.valid    = 1'b0;
      csr_if.data     = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opener at address 0
      write_address(8'd0);
      send_request(REQ_TICK, 8'h00);
      send_request(REQ_UNUSED, 8'hAA);
      send_request(REQ_BYTE, SYNC_FIRST);
      send_request(REQ_BYTE, SYNC_SECOND);
      send_request(REQ_BYTE, 8'd255);
      send_request(REQ_BYTE, 8'd0);
      send_request(REQ_BYTE, 8'd4);
      send_request(REQ_BYTE, 8'd5);
      send_request(REQ_BYTE, 8'd12);
      send_request(REQ_BYTE, 8'd13);
      send_request(REQ_BYTE, 8'd128);
      send_request(REQ_BYTE, 8'd254);
      send_request(REQ_BYTE, 8'd200);
      send_request(REQ_BYTE, SYNC_FIRST);
      send_request(REQ_BYTE, SYNC_SECOND);
      send_request(REQ_ZERO_CROSS, 8'hFF);
      send_request(REQ_TICK, 8'h55);
      send_request(REQ_TICK, 8'hFF);
      send_request(REQ_UNUSED, 8'h55);
      send_request(REQ_TICK, 8'h00);
      send_request(REQ_ZERO_CROSS, 8'h00);
      send_request(REQ_TICK, 8'hAA);
      drain();

      run_phase(8'd0, 0, 0, 60, 1'b0);
      run_phase(8'd130, 47, 0, 1, 1'b0);
      run_phase(BYTE_W'($urandom_range(0, 12)), 0, 47, 60, 1'b1);
      run_phase(RESET_ADDR, 38, 38, 60, 1'b0);

      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/sapd_pkg.sv
sv/sapd_if.sv
sv/sapd_front.sv
sv/sapd_queue.sv
sv/sapd_back.sv
sv/serial_addressed_phase_dimmer.sv
bench/tb_serial_addressed_phase_dimmer.sv
